@@ rtl/ggc_pkg.sv @@
// Shared constants and types for the greedy graph coloring block.
`timescale 1ns / 1ps
`default_nettype none

package ggc_pkg;

   // Field widths of the request and response words.
   localparam int ROW_W    = 64;
   localparam int VERTEX_W = 6;
   localparam int COLOR_W  = 6;
   localparam int COUNT_W  = 7;

   // Default graph size limit.
   localparam int MAX_VERTICES_DEF = 64;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD   = 3'b001,
      ST_GATHER = 3'b010,
      ST_SCAN   = 3'b100
   } state_type;

endpackage

`default_nettype wire

@@ rtl/greedy_graph_coloring.sv @@
// Greedy graph coloring: row loading, neighbor color gathering and result output.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one adjacency row per request word, one word per cycle
// while it is loading rows, and keeps the diagonal and upper triangle of each
// row in a single-port row memory. The word marked last_row, or the word that
// fills MaxVertices rows, closes the graph and starts coloring; no request
// word is taken until the response for the final vertex has been loaded into
// the output register. Vertex u is colored by reading rows 0..u-1 and their
// colors from the row and color memories, one entry per cycle, to gather the
// taken colors; a linear scan from color 0 then finds the lowest free color c
// and loads the response word, waiting while the output register is full.
// Gathering reads one entry at a time through the one read port of the row
// memory. One response word per vertex leaves in vertex order; color_count
// is valid on the word with last set and zero on all others. No clearing
// pass is needed: every row and color entry is written before it is read.
module greedy_graph_coloring #(
   parameter int MaxVertices = ggc_pkg::MAX_VERTICES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ggc_pkg::ROW_W-1:0]   req_row_bits,
   input  logic                        req_last_row,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ggc_pkg::VERTEX_W-1:0] rsp_vertex,
   output logic [ggc_pkg::COLOR_W-1:0] rsp_color,
   output logic [ggc_pkg::COUNT_W-1:0] rsp_color_count,
   output logic                        rsp_last
);

   import ggc_pkg::*;

   localparam int IdxW = $clog2(MaxVertices);

   // Row memory (diagonal and upper triangle only) and color memory.
   logic [MaxVertices-1:0] adj_mem [MaxVertices];
   logic [IdxW-1:0]        col_mem [MaxVertices];

   state_type              state_ff, state_in;
   logic [IdxW-1:0]        rows_ff, rows_in;
   logic [IdxW-1:0]        vlast_ff, vlast_in;
   logic [IdxW-1:0]        u_ff, u_in;
   logic [IdxW-1:0]        j_ff, j_in;
   logic [IdxW-1:0]        c_ff, c_in;
   logic [IdxW-1:0]        high_ff, high_in;
   logic [MaxVertices-1:0] taken_ff, taken_in;
   logic                   pend_ff, pend_in;
   logic [MaxVertices-1:0] adj_rd_ff;
   logic [IdxW-1:0]        col_rd_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0]    rsp_vertex_ff, rsp_vertex_in;
   logic [COLOR_W-1:0]     rsp_color_ff, rsp_color_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   req_take;
   logic                   graph_end;
   logic                   issue;
   logic                   scan_done;
   logic                   out_free;
   logic [MaxVertices-1:0] row_keep;
   logic [IdxW-1:0]        high_new;

   assign req_stall = (state_ff != ST_LOAD);
   assign req_take  = req_valid && !req_stall;
   assign graph_end = req_last_row || (rows_ff == IdxW'(MaxVertices - 1));
   assign row_keep  = req_row_bits[MaxVertices-1:0] & ({MaxVertices{1'b1}} << rows_ff);
   assign issue     = (state_ff == ST_GATHER) && (j_ff != u_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_done = !((c_ff != IdxW'(MaxVertices - 1)) && taken_ff[c_ff]);
   assign high_new  = (c_ff > high_ff) ? c_ff : high_ff;

   // Memory writes and registered reads.
   always_ff @(posedge clock) begin
      if (req_take) begin
         adj_mem[rows_ff] <= row_keep;
      end
      if ((state_ff == ST_SCAN) && scan_done && out_free) begin
         col_mem[u_ff] <= c_ff;
      end
      if (issue) begin
         adj_rd_ff <= adj_mem[j_ff];
         col_rd_ff <= col_mem[j_ff];
      end
   end

   // Sequencer: load rows, gather neighbor colors, scan for a free color.
   always_comb begin
      state_in      = state_ff;
      rows_in       = rows_ff;
      vlast_in      = vlast_ff;
      u_in          = u_ff;
      j_in          = j_ff;
      c_in          = c_ff;
      high_in       = high_ff;
      taken_in      = taken_ff;
      pend_in       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (graph_end) begin
                  rows_in  = '0;
                  vlast_in = rows_ff;
                  u_in     = '0;
                  j_in     = '0;
                  high_in  = '0;
                  taken_in = '0;
                  state_in = ST_GATHER;
               end else begin
                  rows_in = rows_ff + IdxW'(1);
               end
            end
         end
         ST_GATHER: begin
            if (issue) begin
               j_in    = j_ff + IdxW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff && adj_rd_ff[u_ff]) begin
               taken_in = taken_ff | (MaxVertices'(1) << col_rd_ff);
            end
            if (!issue && !pend_ff) begin
               c_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!scan_done) begin
               c_in = c_ff + IdxW'(1);
            end else if (out_free) begin
               high_in       = high_new;
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = VERTEX_W'(u_ff);
               rsp_color_in  = COLOR_W'(c_ff);
               rsp_last_in   = (u_ff == vlast_ff);
               rsp_count_in  = (u_ff == vlast_ff) ? COUNT_W'(high_new) + COUNT_W'(1) : '0;
               if (u_ff == vlast_ff) begin
                  state_in = ST_LOAD;
               end else begin
                  u_in     = u_ff + IdxW'(1);
                  j_in     = '0;
                  taken_in = '0;
                  state_in = ST_GATHER;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rows_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         high_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         high_ff      <= high_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      vlast_ff      <= vlast_in;
      u_ff          <= u_in;
      j_ff          <= j_in;
      c_ff          <= c_in;
      taken_ff      <= taken_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_vertex      = rsp_vertex_ff;
   assign rsp_color       = rsp_color_ff;
   assign rsp_color_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   // A greedy color never exceeds the vertex index.
   a_color_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_color <= rsp_vertex))
      else $error("color above vertex index");

   // The color count is set on the final word only.
   a_count_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_color_count != '0)))
      else $error("color count does not match last flag");

   // The final word's count covers its own color.
   a_count_cover: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (COUNT_W'(rsp_color) < rsp_color_count))
      else $error("color count below final color");

   // Reads return only while gathering, and rows are never taken then.
   a_pend_gather: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> ((state_ff == ST_GATHER) && req_stall))
      else $error("read return outside gather phase");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the greedy graph coloring block.
`timescale 1ns / 1ps

module tb_top;
   import ggc_pkg::*;

   localparam int NUM_VERTICES = 64;
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 50;

   // One response word: the color given to one vertex.
   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic [COLOR_W-1:0]  color;
      logic [COUNT_W-1:0]  count;
      logic                last;
   } vertex_color_type;

   // One row of the directed table. Rows that close a small graph may carry
   // hand-written colors; all other rows are checked against the predictor.
   typedef struct {
      logic [ROW_W-1:0]              bits;
      logic                          last_row;
      bit                            typed;
      int                            n_vert;
      logic [3:0][COLOR_W-1:0]       colors;
      logic [COUNT_W-1:0]            n_colors;
   } graph_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ROW_W-1:0]    req_row_bits = '0;
   logic                req_last_row = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [VERTEX_W-1:0] rsp_vertex;
   logic [COLOR_W-1:0]  rsp_color;
   logic [COUNT_W-1:0]  rsp_color_count;
   logic                rsp_last;

   // Predictor state: the graph being loaded.
   logic [ROW_W-1:0]    adj_rows [NUM_VERTICES];
   int                  rows_held = 0;
   vertex_color_type    vertex_colors_due [$];
   graph_row_type       dir_rows [$];

   int                  send_idle_pct = 20;
   int                  rcv_idle_pct = 69;
   int                  mismatches = 0;
   int                  quiet_cycles = 0;

   greedy_graph_coloring uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_row_bits    (req_row_bits),
      .req_last_row    (req_last_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_vertex      (rsp_vertex),
      .rsp_color       (rsp_color),
      .rsp_color_count (rsp_color_count),
      .rsp_last        (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic log_mismatch(input string field, input int got, input int want);
      $display("mismatch in %s: got %0d, want %0d", field, got, want);
      mismatches++;
   endtask

   // Append one row to the directed table.
   task automatic add_row(input graph_row_type row);
      dir_rows.insert(dir_rows.size(), row);
   endtask

   // Load one row into the predicted graph and, when the row closes the graph,
   // color it greedily and queue one expected word per vertex.
   task automatic color_greedy(input logic [ROW_W-1:0] bits, input logic last_in,
                               input bit push_due);
      int                  r;
      int                  u;
      int                  j;
      int                  c;
      logic [ROW_W-1:0]    kept;
      logic [63:0]         taken;
      logic [COLOR_W-1:0]  hue [NUM_VERTICES];
      logic [COLOR_W-1:0]  top;
      vertex_color_type    vc;
      r = rows_held % NUM_VERTICES;
      // Only the diagonal and the upper triangle count, mirrored both ways.
      kept = bits & ({ROW_W{1'b1}} << r);
      adj_rows[r] |= kept;
      for (j = 0; j < NUM_VERTICES; j++) begin
         if (kept[j]) adj_rows[j][r] = 1'b1;
      end
      rows_held = r + 1;
      if (!last_in && rows_held < NUM_VERTICES) return;
      // Each vertex takes the lowest color that no earlier neighbor holds.
      hue[0] = '0;
      top = '0;
      for (u = 1; u < rows_held; u++) begin
         taken = '0;
         for (j = 0; j < u; j++) begin
            if (adj_rows[u][j]) taken[hue[j]] = 1'b1;
         end
         c = 0;
         while (c < 63 && taken[c]) c++;
         hue[u] = c[COLOR_W-1:0];
         if (hue[u] > top) top = hue[u];
      end
      if (push_due) begin
         for (u = 0; u < rows_held; u++) begin
            vc.vertex = u[VERTEX_W-1:0];
            vc.color  = hue[u];
            vc.last   = (u == rows_held - 1);
            vc.count  = vc.last ? {1'b0, top} + 7'd1 : '0;
            vertex_colors_due.insert(vertex_colors_due.size(), vc);
         end
      end
      // The next graph starts from an empty store.
      for (u = 0; u < NUM_VERTICES; u++) adj_rows[u] = '0;
      rows_held = 0;
   endtask

   // Drive one request word, with random idle cycles in front, and wait until
   // it is accepted. Returns in the time step of the accepting edge.
   task automatic send_row(input logic [ROW_W-1:0] bits, input logic last_in);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid    <= 1'b0;
         req_row_bits <= {$urandom, $urandom};
         req_last_row <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_row_bits <= bits;
      req_last_row <= last_in;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Send a random graph of n_vert rows. A graph of the full size may end
   // through the row limit alone, without last_row.
   task automatic send_graph(input int n_vert);
      int                dens;
      logic [ROW_W-1:0]  a;
      logic [ROW_W-1:0]  b;
      logic [ROW_W-1:0]  c;
      logic [ROW_W-1:0]  bits;
      logic              lst;
      dens = $urandom_range(5);
      for (int r = 0; r < n_vert; r++) begin
         a = {$urandom, $urandom};
         b = {$urandom, $urandom};
         c = {$urandom, $urandom};
         case (dens)
            0:       bits = a & b & c;
            1:       bits = a & b;
            2:       bits = a | b;
            3:       bits = '1;
            4:       bits = '0;
            default: bits = a;
         endcase
         lst = (r == n_vert - 1) && (n_vert < NUM_VERTICES || $urandom_range(1) == 1);
         send_row(bits, lst);
         color_greedy(bits, lst, 1'b1);
      end
   endtask

   // Receiver stall pattern.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
   end

   // Compare each accepted response word with the oldest expected one.
   always @(posedge clock) begin
      vertex_color_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (vertex_colors_due.size() == 0) begin
            log_mismatch("unexpected word, vertex", int'(rsp_vertex), -1);
         end else begin
            want = vertex_colors_due.pop_front();
            if (rsp_vertex !== want.vertex)
               log_mismatch("vertex", int'(rsp_vertex), int'(want.vertex));
            if (rsp_color !== want.color)
               log_mismatch("color", int'(rsp_color), int'(want.color));
            if (rsp_color_count !== want.count)
               log_mismatch("color_count", int'(rsp_color_count), int'(want.count));
            if (rsp_last !== want.last)
               log_mismatch("last", int'(rsp_last), int'(want.last));
         end
      end
   end

   // Watchdog: too long without any word moving on either side ends the run.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   initial begin
      graph_row_type     e;
      vertex_color_type  vc;
      int                k;
      int                sent;
      int                n;
      for (k = 0; k < NUM_VERTICES; k++) adj_rows[k] = '0;

      // Single vertex with every bit set, then a single empty vertex.
      add_row('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1, 24'h0, 7'd1});
      add_row('{64'h0, 1'b1, 1'b1, 1, 24'h0, 7'd1});
      // One edge, with a lower-triangle bit on the second row.
      add_row('{64'h2, 1'b0, 1'b0, 0, 24'h0, 7'd0});
      add_row('{64'h1, 1'b1, 1'b1, 2, {6'd0, 6'd0, 6'd1, 6'd0}, 7'd2});
      // Only a lower-triangle bit: no edge.
      add_row('{64'h0, 1'b0, 1'b0, 0, 24'h0, 7'd0});
      add_row('{64'h1, 1'b1, 1'b1, 2, 24'h0, 7'd1});
      // Triangle, then an empty graph to show that no edge of the triangle remains.
      add_row('{64'h6, 1'b0, 1'b0, 0, 24'h0, 7'd0});
      add_row('{64'h4, 1'b0, 1'b0, 0, 24'h0, 7'd0});
      add_row('{64'h0, 1'b1, 1'b1, 3, {6'd0, 6'd2, 6'd1, 6'd0}, 7'd3});
      add_row('{64'h0, 1'b0, 1'b0, 0, 24'h0, 7'd0});
      add_row('{64'h0, 1'b0, 1'b0, 0, 24'h0, 7'd0});
      add_row('{64'h0, 1'b1, 1'b1, 3, 24'h0, 7'd1});
      // Edge to a vertex beyond the graph.
      add_row('{64'h8000_0000_0000_0000, 1'b0, 1'b0, 0, 24'h0, 7'd0});
      add_row('{64'h0, 1'b1, 1'b1, 2, 24'h0, 7'd1});
      // Self loops next to a real edge.
      add_row('{64'h3, 1'b0, 1'b0, 0, 24'h0, 7'd0});
      add_row('{64'h2, 1'b1, 1'b1, 2, {6'd0, 6'd0, 6'd1, 6'd0}, 7'd2});
      // Colors reused along a path, and alternating bit patterns.
      add_row('{64'h4, 1'b0, 1'b0, 0, 24'h0, 7'd0});
      add_row('{64'h4, 1'b0, 1'b0, 0, 24'h0, 7'd0});
      add_row('{64'h0, 1'b1, 1'b0, 0, 24'h0, 7'd0});
      add_row('{64'h5555_5555_5555_5555, 1'b0, 1'b0, 0, 24'h0, 7'd0});
      add_row('{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 0, 24'h0, 7'd0});
      add_row('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 0, 24'h0, 7'd0});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      foreach (dir_rows[i]) begin
         e = dir_rows[i];
         send_row(e.bits, e.last_row);
         color_greedy(e.bits, e.last_row, !e.typed);
         if (e.typed) begin
            for (k = 0; k < e.n_vert; k++) begin
               vc.vertex = k[VERTEX_W-1:0];
               vc.color  = e.colors[k];
               vc.last   = (k == e.n_vert - 1);
               vc.count  = vc.last ? e.n_colors : '0;
               vertex_colors_due.insert(vertex_colors_due.size(), vc);
            end
         end
      end

      // Random graphs in three idling phases; the last one opens with a
      // graph of the full size.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 20;
               rcv_idle_pct  = 69;
            end
            1: begin
               send_idle_pct = 69;
               rcv_idle_pct  = 20;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
            end
         endcase
         sent = 0;
         if (phase == 2) begin
            send_graph(NUM_VERTICES);
            sent = NUM_VERTICES;
         end
         while (sent < 22) begin
            if ($urandom_range(7) == 0) n = $urandom_range(30, 11);
            else n = $urandom_range(10, 1);
            send_graph(n);
            sent += n;
         end
      end
      req_valid <= 1'b0;

      // Drain all expected words, then let the block settle.
      while (vertex_colors_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/ggc_pkg.sv
rtl/greedy_graph_coloring.sv
tb/tb_top.sv
